@@ rtl/text_terminal_cell_writer_defines.svh @@
// Assertion macros for the text terminal cell writer checker
`ifndef TEXT_TERMINAL_CELL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_CELL_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define TTCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TTCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ttcw_pkg.sv @@
// Package: screen geometry, field widths, codes and shared types for the cell writer
`timescale 1ns / 1ps
`default_nettype none

package ttcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int KEEP_COUNT = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int ACTION_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int CELL_W    = 16;
   localparam int COLOR_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_FG     = 4'd7;
   localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR = 2'd0,
      CSR_BG_COLOR = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      FILL_INIT,
      FILL_CLEAR,
      FILL_SCROLL
   } fill_mode_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] value;
   } result_type;

   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0]  ch,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg);
      return {bg, fg, ch};
   endfunction

endpackage

`default_nettype wire

@@ rtl/text_terminal_cell_writer.sv @@
// Top level: text screen cell writer with colour registers and result register
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/req_stall | action, char_code, read_row, read_col
//   rsp_    | out       | rsp_valid/rsp_stall | cursor_row, cursor_col, cell_value
//   csr_    | in        | csr_valid/csr_ready | index, wdata (colour registers)
//
// Put, plain newline, off-screen read and unused action go straight on to load the
// result, a put writing its cell as it is accepted; an on-screen read first takes
// the registered read data from the cell memory. Clear and scrolling newline first
// run one sweep over the store. After reset the store is blanked with req_stall high;
// colour writes are taken throughout. One item is in work at a time, and a result
// held by rsp_stall keeps the next one from finishing, with req_stall high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_cell_writer (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [ttcw_pkg::ACTION_W-1:0]   req_action,
   input  wire [ttcw_pkg::CHAR_W-1:0]     req_char_code,
   input  wire [ttcw_pkg::ROW_W-1:0]      req_read_row,
   input  wire [ttcw_pkg::COL_W-1:0]      req_read_col,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [ttcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [ttcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [ttcw_pkg::CELL_W-1:0]    rsp_cell_value,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [ttcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [ttcw_pkg::COLOR_W-1:0]    csr_wdata
);
   import ttcw_pkg::*;

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [CELL_W-1:0]  rsp_value_ff;

   logic               rsp_free;
   logic               rsp_load;
   mem_req_type        mem_req;
   logic [CELL_W-1:0]  rd_data;
   result_type         result;

   // colour registers: always ready, unknown indexes drop the word
   assign csr_ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FG_COLOR: fg_in = csr_wdata;
            CSR_BG_COLOR: bg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= RESET_FG;
         bg_ff <= RESET_BG;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   ttcw_cell_ram u_cell_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ttcw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .fg_color      (fg_ff),
      .bg_color      (bg_ff),
      .rsp_free      (rsp_free),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .result        (result)
   );

   // result register: hold while stalled, advance when empty or being taken
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = result.valid && rsp_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff   <= result.row;
         rsp_col_ff   <= result.col;
         rsp_value_ff <= result.value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_value = rsp_value_ff;

endmodule

`default_nettype wire

@@ rtl/ttcw_cell_ram.sv @@
// Screen cell memory: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none

module ttcw_cell_ram (
   input  wire                          clock,
   input  ttcw_pkg::mem_req_type        mem_req,
   output logic [ttcw_pkg::CELL_W-1:0]  rd_data
);
   import ttcw_pkg::*;

   logic [CELL_W-1:0] cells_ff [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         cells_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= cells_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ttcw_ctrl.sv @@
// Sequencer: cursor, per-item memory access, and the fill / scroll sweep over the store
`timescale 1ns / 1ps
`default_nettype none

module ttcw_ctrl (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [ttcw_pkg::ACTION_W-1:0]    req_action,
   input  wire [ttcw_pkg::CHAR_W-1:0]      req_char_code,
   input  wire [ttcw_pkg::ROW_W-1:0]       req_read_row,
   input  wire [ttcw_pkg::COL_W-1:0]       req_read_col,
   input  wire [ttcw_pkg::COLOR_W-1:0]     fg_color,
   input  wire [ttcw_pkg::COLOR_W-1:0]     bg_color,
   input  wire                             rsp_free,
   output ttcw_pkg::mem_req_type           mem_req,
   input  wire [ttcw_pkg::CELL_W-1:0]      rd_data,
   output ttcw_pkg::result_type            result
);
   import ttcw_pkg::*;

   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] KEEP_A     = ADDR_W'(KEEP_COUNT);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);

   state_type         state_ff, state_in;
   fill_mode_type     mode_ff, mode_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              stage_valid_ff, stage_valid_in;
   logic [ADDR_W-1:0] stage_addr_ff, stage_addr_in;
   logic              stage_keep_ff, stage_keep_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] value_ff, value_in;

   logic              accept;
   logic              is_newline;
   logic              last_row;
   logic              last_col;
   logic              read_ok;
   logic              sweep_keep;
   logic [ADDR_W-1:0] cursor_addr;
   logic [ADDR_W-1:0] read_addr;
   logic [CELL_W-1:0] blank;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign is_newline  = (req_char_code == NEWLINE_CODE);
   assign last_row    = (row_ff == ROW_LAST);
   assign last_col    = (col_ff == COL_LAST);
   assign read_ok     = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
   assign sweep_keep  = (mode_ff == FILL_SCROLL) && (sweep_ff < KEEP_A);
   assign cursor_addr = ADDR_W'(ADDR_W'(row_ff) * COLS_A) + ADDR_W'(col_ff);
   assign read_addr   = ADDR_W'(ADDR_W'(req_read_row) * COLS_A) + ADDR_W'(req_read_col);
   assign blank       = (mode_ff == FILL_INIT) ? make_cell(SPACE_CODE, RESET_FG, RESET_BG)
                                               : make_cell(SPACE_CODE, fg_color, bg_color);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action_type'(req_action))
                  ACT_PUT:   state_in = (is_newline && last_row) ? ST_SWEEP : ST_FINISH;
                  ACT_CLEAR: state_in = ST_SWEEP;
                  ACT_READ:  state_in = read_ok ? ST_READ_WAIT : ST_FINISH;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_SWEEP: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = (mode_ff == FILL_INIT) ? ST_IDLE : ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      mode_in        = mode_ff;
      sweep_in       = sweep_ff;
      stage_valid_in = 1'b0;
      stage_addr_in  = stage_addr_ff;
      stage_keep_in  = stage_keep_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      value_in       = value_ff;
      mem_req        = '0;

      // write back the staged sweep word; rd_data holds its source cell
      if (stage_valid_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = stage_addr_ff;
         mem_req.wr_data = stage_keep_ff ?
                           make_cell(rd_data[CHAR_W-1:0], fg_color, bg_color) : blank;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = '0;
               case (action_type'(req_action))
                  ACT_PUT: begin
                     if (is_newline) begin
                        col_in = '0;
                        if (last_row) begin
                           mode_in  = FILL_SCROLL;
                           sweep_in = '0;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = cursor_addr;
                        mem_req.wr_data = make_cell(req_char_code, fg_color, bg_color);
                        if (last_col) begin
                           col_in = '0;
                           row_in = last_row ? '0 : row_ff + ROW_W'(1);
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     mode_in  = FILL_CLEAR;
                     sweep_in = '0;
                  end
                  ACT_READ: begin
                     if (read_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = read_addr;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: value_in = rd_data;
         ST_SWEEP: begin
            mem_req.rd_en   = sweep_keep;
            mem_req.rd_addr = sweep_ff + COLS_A;
            stage_valid_in  = 1'b1;
            stage_addr_in   = sweep_ff;
            stage_keep_in   = sweep_keep;
            sweep_in        = sweep_ff + ADDR_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         mode_ff        <= FILL_INIT;
         sweep_ff       <= '0;
         stage_valid_ff <= 1'b0;
         row_ff         <= '0;
         col_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         sweep_ff       <= sweep_in;
         stage_valid_ff <= stage_valid_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_addr_ff <= stage_addr_in;
      stage_keep_ff <= stage_keep_in;
      value_ff      <= value_in;
   end

   assign result.valid = (state_ff == ST_FINISH);
   assign result.row   = row_ff;
   assign result.col   = col_ff;
   assign result.value = value_ff;

endmodule

`default_nettype wire

@@ rtl/ttcw_checker.sv @@
// Port checker for the text terminal cell writer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "text_terminal_cell_writer_defines.svh"

module ttcw_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_stall,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [ttcw_pkg::ROW_W-1:0]      rsp_cursor_row,
   input wire [ttcw_pkg::COL_W-1:0]      rsp_cursor_col,
   input wire [ttcw_pkg::CELL_W-1:0]     rsp_cell_value
);
   import ttcw_pkg::*;

   logic                            req_take;
   logic                            rsp_wait;
   logic                            row_ok;
   logic                            col_ok;
   logic [ROW_W+COL_W+CELL_W-1:0]   rsp_word;

   assign req_take = req_valid && !req_stall;
   assign rsp_wait = rsp_valid && rsp_stall;
   assign row_ok   = (32'(rsp_cursor_row) < ROWS);
   assign col_ok   = (32'(rsp_cursor_col) < COLUMNS);
   assign rsp_word = {rsp_cursor_row, rsp_cursor_col, rsp_cell_value};

   // one word in work at a time: the cycle after an accept is stalled
   `TTCW_ASSERT_NEXT(a_one_in_work, clock, reset, req_take, req_stall, "second word taken")

   `TTCW_ASSERT_IMPL(a_col_in_range, clock, reset, rsp_valid, col_ok, "column off screen")

   `TTCW_ASSERT_IMPL(a_row_in_range, clock, reset, rsp_valid, row_ok, "row off screen")

   `TTCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word), "held")

endmodule

bind text_terminal_cell_writer ttcw_checker u_ttcw_checker (.*);

`default_nettype wire

@@ bench/text_terminal_cell_writer_tb.sv @@
// Self-checking bench for the text screen cell writer: scripted and random words, shadow screen
`timescale 1ns / 1ps

module text_terminal_cell_writer_tb;
   import ttcw_pkg::*;

   // Action code the block leaves unmapped, and colour register slots past the list
   localparam logic [ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7E;

   localparam int RESET_CYCLES    = 11;
   localparam int IDLE_PCT        = 29;
   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 215; // the last group of a phase can run over by up to 169
   localparam int SQUEEZE_PHASE   = 4;   // receiver holds off for a long stretch
   localparam int CALM_PHASE      = 5;   // neither side idles
   localparam int HOLD_CYCLES     = 500;
   localparam int SETTLE_CYCLES   = 8;   // quiet gap after the last result, with some margin
   localparam int MAX_REPORTED    = 10;
   // Slowest legal run: every word a full-screen sweep plus gaps on both sides, for
   // every word of every phase, plus the blanking pass after reset; taken with wide margin.
   localparam longint TIMEOUT_CYCLES = 64'd12_000_000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   char_code;
      logic [ROW_W-1:0]    read_row;
      logic [COL_W-1:0]    read_col;
   } screen_op_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] value;
   } cursor_report_type;

   typedef struct {
      screen_op_type     op;
      bit                pinned;   // expectation typed in by hand
      cursor_report_type want;
   } directed_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action;
   logic [CHAR_W-1:0]    req_char_code;
   logic [ROW_W-1:0]     req_read_row;
   logic [COL_W-1:0]     req_read_col;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ROW_W-1:0]     rsp_cursor_row;
   logic [COL_W-1:0]     rsp_cursor_col;
   logic [CELL_W-1:0]    rsp_cell_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0]   csr_wdata;

   text_terminal_cell_writer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_value (rsp_cell_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Shadow of the screen, cursor and colour registers
   logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
   int                 shadow_row;
   int                 shadow_col;
   logic [COLOR_W-1:0] shadow_fg;
   logic [COLOR_W-1:0] shadow_bg;

   cursor_report_type pending_reports [$];
   directed_row_type  directed_rows [$];

   int     idle_pct = IDLE_PCT;
   int     hold_asked = 0;
   int     hold_done = 0;
   int     mismatches = 0;
   int     results_seen = 0;
   int     counted_items = 0;
   longint cycle_count = 0;

   // Tallies for the closing summary
   int n_puts = 0, n_newlines = 0, n_scrolls = 0, n_bottom_wraps = 0, n_clears = 0;
   int n_reads = 0, n_wild_reads = 0, n_unused = 0, n_colour_writes = 0;

   cursor_report_type got_report;
   cursor_report_type want_report;

   // Free-running clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs anywhere
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, pending_reports.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [CELL_W-1:0] paint_cell(input logic [CHAR_W-1:0] ch);
      return {shadow_bg, shadow_fg, ch};
   endfunction

   task automatic blank_shadow();
      for (int i = 0; i < CELL_COUNT; i++)
         shadow_cells[i] = paint_cell(SPACE_CODE);
   endtask

   // Advance the shadow by one word and work out the result it must produce
   task automatic apply_screen_op(input screen_op_type op, output cursor_report_type rep);
      rep = '0;
      case (op.action)
         ACT_PUT: begin
            if (op.char_code == NEWLINE_CODE) begin
               // Newline writes nothing; on the bottom row it scrolls and recolours
               shadow_col = 0;
               if (shadow_row == ROWS - 1) begin
                  for (int i = COLUMNS; i < CELL_COUNT; i++)
                     shadow_cells[i - COLUMNS] = paint_cell(shadow_cells[i][CHAR_W-1:0]);
                  for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                     shadow_cells[i] = paint_cell(SPACE_CODE);
                  n_scrolls++;
               end else begin
                  shadow_row++;
               end
               n_newlines++;
            end else begin
               shadow_cells[shadow_row * COLUMNS + shadow_col] = paint_cell(op.char_code);
               shadow_col++;
               // Past the last column: next row, and past the bottom back to the top
               if (shadow_col == COLUMNS) begin
                  shadow_col = 0;
                  if (shadow_row == ROWS - 1) begin
                     shadow_row = 0;
                     n_bottom_wraps++;
                  end else begin
                     shadow_row++;
                  end
               end
               n_puts++;
            end
         end
         ACT_CLEAR: begin
            blank_shadow();
            shadow_row = 0;
            shadow_col = 0;
            n_clears++;
         end
         ACT_READ: begin
            if (op.read_row < ROWS && op.read_col < COLUMNS)
               rep.value = shadow_cells[op.read_row * COLUMNS + op.read_col];
            else
               n_wild_reads++;
            n_reads++;
         end
         default: n_unused++;
      endcase
      rep.row = shadow_row[ROW_W-1:0];
      rep.col = shadow_col[COL_W-1:0];
   endtask

   // Offer one word, hold it until taken, then log what must come back.
   // Entered and left just after a falling edge.
   task automatic send_op(input screen_op_type op, input bit pinned,
                          input cursor_report_type pinned_rep);
      cursor_report_type rep;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= op.action;
      req_char_code <= op.char_code;
      req_read_row  <= op.read_row;
      req_read_col  <= op.read_col;
      do @(posedge clock); while (req_stall);
      apply_screen_op(op, rep);
      pending_reports.push_back(pinned ? pinned_rep : rep);
      if (op.action != ACT_UNUSED)
         counted_items++;
      @(negedge clock);
   endtask

   task automatic send_checked(input screen_op_type op);
      send_op(op, 1'b0, '0);
   endtask

   task automatic add_row(input screen_op_type op, input bit pinned,
                          input cursor_report_type want);
      directed_row_type r;
      r.op     = op;
      r.pinned = pinned;
      r.want   = want;
      directed_rows.push_back(r);
   endtask

   // Write one colour register; leaves csr_valid high for the caller to drop
   task automatic write_colour_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [COLOR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FG_COLOR)
         shadow_fg = data;
      else if (idx == CSR_BG_COLOR)
         shadow_bg = data;
      n_colour_writes++;
      @(negedge clock);
   endtask

   // Wait for every outstanding result, then let the block go quiet
   task automatic settle();
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic screen_op_type put_word(input logic [CHAR_W-1:0] ch);
      screen_op_type op;
      op.action    = ACT_PUT;
      op.char_code = ch;
      op.read_row  = ROW_W'($urandom);   // don't-care fields carry junk
      op.read_col  = COL_W'($urandom);
      return op;
   endfunction

   function automatic screen_op_type read_word(input int r, input int c);
      screen_op_type op;
      op.action    = ACT_READ;
      op.char_code = CHAR_W'($urandom);
      op.read_row  = ROW_W'(r);
      op.read_col  = COL_W'(c);
      return op;
   endfunction

   // Receiver: random stalls, or one long hold-off when asked for
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         got_report = {rsp_cursor_row, rsp_cursor_col, rsp_cell_value};
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
               $display("unexpected result at cycle %0d: row %0d col %0d cell %h",
                        cycle_count, got_report.row, got_report.col, got_report.value);
         end else begin
            want_report = pending_reports.pop_front();
            if (got_report.row !== want_report.row || got_report.col !== want_report.col ||
                got_report.value !== want_report.value) begin
               mismatches++;
               if (mismatches <= MAX_REPORTED)
                  $display("result %0d @%0d exp/got: row %0d/%0d col %0d/%0d cell %h/%h",
                           results_seen, cycle_count, want_report.row, got_report.row,
                           want_report.col, got_report.col, want_report.value,
                           got_report.value);
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      screen_op_type     op;
      cursor_report_type nil_rep;
      int                pick;
      int                len;
      int                phase_start;
      int                r;
      logic [COLOR_W-1:0] fg_pick;
      logic [COLOR_W-1:0] bg_pick;

      nil_rep       = '0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_PUT;
      req_char_code = '0;
      req_read_row  = '0;
      req_read_col  = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_FG_COLOR;
      csr_wdata     = '0;

      shadow_fg  = RESET_FG;
      shadow_bg  = RESET_BG;
      shadow_row = 0;
      shadow_col = 0;
      blank_shadow();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scripted words at reset colours; the blanking pass after reset holds the
      // first word off through req_stall, so no explicit wait is needed here.
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd0}, 1'b1,
              cursor_report_type'{5'd0, 7'd0, 16'h0720});
      add_row(screen_op_type'{ACT_READ, 8'hFF, 5'd24, 7'd79}, 1'b1,
              cursor_report_type'{5'd0, 7'd0, 16'h0720});
      // Reads past the bottom row or the last column return zero
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd25, 7'd0}, 1'b1, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd80}, 1'b1, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd31, 7'd127}, 1'b1, nil_rep);
      // Unmapped action: cursor unchanged, zero cell
      add_row(screen_op_type'{ACT_UNUSED, 8'hFF, 5'd31, 7'd127}, 1'b1, nil_rep);
      add_row(screen_op_type'{ACT_PUT, 8'h41, 5'd31, 7'd127}, 1'b1,
              cursor_report_type'{5'd0, 7'd1, 16'h0000});
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd0}, 1'b1,
              cursor_report_type'{5'd0, 7'd1, 16'h0741});
      add_row(screen_op_type'{ACT_PUT, 8'hFF, 5'd0, 7'd0}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_PUT, 8'h00, 5'd0, 7'd0}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd1}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd2}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_PUT, NEWLINE_CODE, 5'd0, 7'd0}, 1'b1,
              cursor_report_type'{5'd1, 7'd0, 16'h0000});
      add_row(screen_op_type'{ACT_PUT, SPACE_CODE, 5'd0, 7'd0}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd1, 7'd0}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd79}, 1'b0, nil_rep);
      add_row(screen_op_type'{ACT_CLEAR, 8'hFF, 5'd31, 7'd127}, 1'b1, nil_rep);
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd0, 7'd0}, 1'b1,
              cursor_report_type'{5'd0, 7'd0, 16'h0720});
      add_row(screen_op_type'{ACT_READ, 8'h00, 5'd1, 7'd0}, 1'b0, nil_rep);

      foreach (directed_rows[i])
         send_op(directed_rows[i].op, directed_rows[i].pinned, directed_rows[i].want);
      req_valid <= 1'b0;
      settle();
      counted_items = 0;

      // Random phases, each under its own colour setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       begin fg_pick = 4'hF; bg_pick = 4'hF; end
            1:       begin fg_pick = 4'h0; bg_pick = 4'h0; end
            2:       begin fg_pick = 4'hF; bg_pick = 4'h0; end
            3:       begin fg_pick = 4'h0; bg_pick = 4'hF; end
            default: begin fg_pick = COLOR_W'($urandom); bg_pick = COLOR_W'($urandom); end
         endcase
         write_colour_reg(CSR_FG_COLOR, fg_pick);
         write_colour_reg(CSR_BG_COLOR, bg_pick);
         // Slots past the list must be dropped
         write_colour_reg(phase[0] ? CSR_SPARE_HI : CSR_SPARE_LO, COLOR_W'($urandom));
         csr_valid <= 1'b0;

         idle_pct = (phase == CALM_PHASE) ? 0 : IDLE_PCT;
         if (phase == SQUEEZE_PHASE) begin
            // Ask for the hold-off away from the falling edge the receiver acts on
            @(posedge clock);
            hold_asked++;
            @(negedge clock);
         end

         phase_start = counted_items;
         while (counted_items - phase_start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 38) begin
               // A line of text, usually ended by a newline
               len = $urandom_range(60, 3);
               for (int k = 0; k < len; k++)
                  send_checked(put_word(CHAR_W'($urandom_range(PRINT_HI, PRINT_LO))));
               if ($urandom_range(9) < 7)
                  send_checked(put_word(NEWLINE_CODE));
            end else if (pick < 46) begin
               // Long run with no newline: wraps columns, and off the bottom row to the top
               len = $urandom_range(170, 80);
               for (int k = 0; k < len; k++)
                  send_checked(put_word(CHAR_W'($urandom_range(PRINT_HI, PRINT_LO))));
            end else if (pick < 56) begin
               // Newlines in a row; on the bottom row each one scrolls
               len = $urandom_range(6, 1);
               for (int k = 0; k < len; k++)
                  send_checked(put_word(NEWLINE_CODE));
            end else if (pick < 78) begin
               // Read back, half of them around the cursor where the last writes landed
               len = $urandom_range(20, 4);
               for (int k = 0; k < len; k++) begin
                  r = $urandom_range(9);
                  if (r < 5)
                     send_checked(read_word(shadow_row - ((shadow_row > 0) ? $urandom_range(1) : 0),
                                            $urandom_range(COLUMNS - 1)));
                  else if (r < 9)
                     send_checked(read_word($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1)));
                  else
                     send_checked(read_word($urandom_range(31), $urandom_range(127)));
               end
            end else if (pick < 80) begin
               send_checked(screen_op_type'{ACT_CLEAR, CHAR_W'($urandom), ROW_W'($urandom),
                                            COL_W'($urandom)});
            end else begin
               // Noise: any action, any byte, any coordinates
               len = $urandom_range(8, 1);
               for (int k = 0; k < len; k++) begin
                  r = $urandom_range(99);
                  op.char_code = CHAR_W'($urandom);
                  op.read_row  = ROW_W'($urandom);
                  op.read_col  = COL_W'($urandom);
                  if (r < 40)
                     op.action = ACT_PUT;
                  else if (r < 80)
                     op.action = ACT_READ;
                  else if (r < 95)
                     op.action = ACT_UNUSED;
                  else
                     op.action = ACT_CLEAR;
                  send_checked(op);
               end
            end
         end
         req_valid <= 1'b0;
         settle();
      end

      idle_pct = IDLE_PCT;
      if (pending_reports.size() != 0)
         $display("%0d results never arrived", pending_reports.size());

      $display("covered %0d chars, %0d newlines (%0d scrolls), %0d bottom wraps, %0d clears",
               n_puts, n_newlines, n_scrolls, n_bottom_wraps, n_clears);
      $display("%0d reads (%0d off screen), %0d unused, %0d colour writes; %0d results, %0d bad",
               n_reads, n_wild_reads, n_unused, n_colour_writes, results_seen, mismatches);

      if (mismatches == 0 && pending_reports.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
